@@ src/sirc_pkg.sv @@
// Shared types, constants and field widths of the infrared pulse decoder.
`timescale 1ns / 1ps

package sirc_pkg;

  localparam int TICKS_PER_10US = 8;
  localparam int DURATION_BITS  = 15;

  localparam int TICKS_W  = 15;
  localparam int TGT_W    = 15;
  localparam int MARGIN_W = 12;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W    = 5;
  localparam int CMD_W    = 20;

  localparam int TICK_USE_W = (DURATION_BITS < TICKS_W) ? DURATION_BITS : TICKS_W;
  localparam int PROD_W     = TICK_USE_W + 4;
  localparam int US_MAX     = ((1 << TICK_USE_W) - 1) * 10 / TICKS_PER_10US;
  localparam int US_W       = (US_MAX < 1) ? 1 : $clog2(US_MAX + 1);
  localparam int CMP_W      = ((US_W > TGT_W) ? US_W : TGT_W) + 1;

  localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(12);
  localparam logic [CNT_W-1:0] LEN_MID   = CNT_W'(15);
  localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(20);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(31);
  localparam logic [CNT_W-1:0] CNT_STORE = CNT_W'(CMD_W);

  localparam logic              RST_ACTIVE_LEVEL = 1'b0;
  localparam logic [MARGIN_W-1:0] RST_MARGIN     = MARGIN_W'(100);
  localparam logic [TGT_W-1:0]  RST_HEADER_MARK  = TGT_W'(2400);
  localparam logic [TGT_W-1:0]  RST_HEADER_SPACE = TGT_W'(600);
  localparam logic [TGT_W-1:0]  RST_ONE_MARK     = TGT_W'(1200);
  localparam logic [TGT_W-1:0]  RST_ZERO_MARK    = TGT_W'(600);
  localparam logic [TGT_W-1:0]  RST_BIT_SPACE    = TGT_W'(600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL = 3'd0,
    REG_MARGIN       = 3'd1,
    REG_HEADER_MARK  = 3'd2,
    REG_HEADER_SPACE = 3'd3,
    REG_ONE_MARK     = 3'd4,
    REG_ZERO_MARK    = 3'd5,
    REG_BIT_SPACE    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                active_level;
    logic [MARGIN_W-1:0] slack_us;
    logic [TGT_W-1:0]    header_mark_us;
    logic [TGT_W-1:0]    header_space_us;
    logic [TGT_W-1:0]    one_mark_us;
    logic [TGT_W-1:0]    zero_mark_us;
    logic [TGT_W-1:0]    bit_space_us;
  } cfg_t;

  typedef struct packed {
    logic header;
    logic one;
    logic zero;
    logic last;
  } pair_class_t;

endpackage

@@ src/sirc_cfg.sv @@
// Configuration register file of the infrared pulse decoder.
`timescale 1ns / 1ps

module sirc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sirc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sirc_pkg::CFG_W-1:0]    cfg_data_i,
  output sirc_pkg::cfg_t                cfg_o
);

  sirc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sirc_pkg::cfg_reg_e'(cfg_index_i))
        sirc_pkg::REG_ACTIVE_LEVEL: cfg_d.active_level    = cfg_data_i[0];
        sirc_pkg::REG_MARGIN:       cfg_d.slack_us        = cfg_data_i[sirc_pkg::MARGIN_W-1:0];
        sirc_pkg::REG_HEADER_MARK:  cfg_d.header_mark_us  = cfg_data_i[sirc_pkg::TGT_W-1:0];
        sirc_pkg::REG_HEADER_SPACE: cfg_d.header_space_us = cfg_data_i[sirc_pkg::TGT_W-1:0];
        sirc_pkg::REG_ONE_MARK:     cfg_d.one_mark_us     = cfg_data_i[sirc_pkg::TGT_W-1:0];
        sirc_pkg::REG_ZERO_MARK:    cfg_d.zero_mark_us    = cfg_data_i[sirc_pkg::TGT_W-1:0];
        sirc_pkg::REG_BIT_SPACE:    cfg_d.bit_space_us    = cfg_data_i[sirc_pkg::TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level    <= sirc_pkg::RST_ACTIVE_LEVEL;
      cfg_q.slack_us        <= sirc_pkg::RST_MARGIN;
      cfg_q.header_mark_us  <= sirc_pkg::RST_HEADER_MARK;
      cfg_q.header_space_us <= sirc_pkg::RST_HEADER_SPACE;
      cfg_q.one_mark_us     <= sirc_pkg::RST_ONE_MARK;
      cfg_q.zero_mark_us    <= sirc_pkg::RST_ZERO_MARK;
      cfg_q.bit_space_us    <= sirc_pkg::RST_BIT_SPACE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/sirc_classify.sv @@
// Pulse pair classifier: tick to microsecond conversion and window matching.
`timescale 1ns / 1ps

module sirc_classify (
  input  sirc_pkg::cfg_t                cfg_i,
  input  logic                          first_level_i,
  input  logic [sirc_pkg::TICKS_W-1:0]  first_ticks_i,
  input  logic                          second_level_i,
  input  logic [sirc_pkg::TICKS_W-1:0]  second_ticks_i,
  input  logic                          end_of_buffer_i,
  output sirc_pkg::pair_class_t         cls_o
);

  function automatic logic [sirc_pkg::US_W-1:0] to_us(
    input logic [sirc_pkg::TICKS_W-1:0] ticks
  );
    logic [sirc_pkg::PROD_W-1:0] prod;
    prod = sirc_pkg::PROD_W'(ticks[sirc_pkg::TICK_USE_W-1:0]) * sirc_pkg::PROD_W'(10);
    return sirc_pkg::US_W'(prod / sirc_pkg::PROD_W'(sirc_pkg::TICKS_PER_10US));
  endfunction

  function automatic logic near(
    input logic [sirc_pkg::US_W-1:0]     us,
    input logic [sirc_pkg::TGT_W-1:0]    target,
    input logic [sirc_pkg::MARGIN_W-1:0] margin
  );
    logic [sirc_pkg::CMP_W-1:0] us_x;
    logic [sirc_pkg::CMP_W-1:0] tgt_x;
    logic [sirc_pkg::CMP_W-1:0] mrg_x;
    us_x  = sirc_pkg::CMP_W'(us);
    tgt_x = sirc_pkg::CMP_W'(target);
    mrg_x = sirc_pkg::CMP_W'(margin);
    return (us_x < tgt_x + mrg_x) && (us_x + mrg_x > tgt_x);
  endfunction

  logic [sirc_pkg::US_W-1:0] mark_us;
  logic [sirc_pkg::US_W-1:0] space_us;
  logic                      well;
  logic                      space_ok;

  always_comb begin
    mark_us  = to_us(first_ticks_i);
    space_us = to_us(second_ticks_i);
    well     = (first_level_i == cfg_i.active_level) && (second_level_i != cfg_i.active_level);
    space_ok = end_of_buffer_i || near(space_us, cfg_i.bit_space_us, cfg_i.slack_us);

    cls_o.header = well && near(mark_us, cfg_i.header_mark_us, cfg_i.slack_us)
                   && near(space_us, cfg_i.header_space_us, cfg_i.slack_us);
    cls_o.one    = well && space_ok && near(mark_us, cfg_i.one_mark_us, cfg_i.slack_us);
    cls_o.zero   = well && space_ok && near(mark_us, cfg_i.zero_mark_us, cfg_i.slack_us);
    cls_o.last   = end_of_buffer_i;
  end

endmodule

@@ src/sirc_frame.sv @@
// Frame tracker: bit collection, frame state and the result register.
`timescale 1ns / 1ps

module sirc_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  sirc_pkg::pair_class_t       cls_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        frame_valid_o,
  output logic [sirc_pkg::CNT_W-1:0]  bit_count_o,
  output logic [sirc_pkg::CMD_W-1:0]  command_value_o
);

  logic                       in_frame_q, in_frame_d;
  logic [sirc_pkg::CNT_W-1:0] bits_seen_q, bits_seen_d;
  logic [sirc_pkg::CMD_W-1:0] bit_store_q, bit_store_d;
  logic                       out_valid_q, out_valid_d;
  logic                       frame_valid_q, frame_valid_d;
  logic [sirc_pkg::CNT_W-1:0] bit_count_q, bit_count_d;
  logic [sirc_pkg::CMD_W-1:0] command_value_q, command_value_d;

  logic                       bit_hit;
  logic                       emit_req;
  logic                       emit;
  logic [sirc_pkg::CMD_W-1:0] set_mask;
  logic [sirc_pkg::CNT_W-1:0] bits_inc;
  logic [sirc_pkg::CMD_W-1:0] store_upd;
  logic [sirc_pkg::CNT_W-1:0] res_count;
  logic [sirc_pkg::CMD_W-1:0] res_store;
  logic                       nxt_in_frame;
  logic [sirc_pkg::CNT_W-1:0] nxt_bits;
  logic [sirc_pkg::CMD_W-1:0] nxt_store;
  logic                       len_ok;

  always_comb begin
    bit_hit   = cls_i.one || cls_i.zero;
    set_mask  = (bits_seen_q < sirc_pkg::CNT_STORE) ?
                (sirc_pkg::CMD_W'(1) << bits_seen_q) : '0;
    bits_inc  = (bits_seen_q == sirc_pkg::CNT_MAX) ? bits_seen_q :
                bits_seen_q + sirc_pkg::CNT_W'(1);
    store_upd = bit_store_q | (cls_i.one ? set_mask : '0);

    emit_req     = 1'b0;
    res_count    = '0;
    res_store    = '0;
    nxt_in_frame = in_frame_q;
    nxt_bits     = bits_seen_q;
    nxt_store    = bit_store_q;

    if (in_frame_q) begin
      if (bit_hit) begin
        if (cls_i.last) begin
          emit_req     = 1'b1;
          res_count    = bits_inc;
          res_store    = store_upd;
          nxt_in_frame = 1'b0;
          nxt_bits     = '0;
          nxt_store    = '0;
        end else begin
          nxt_bits  = bits_inc;
          nxt_store = store_upd;
        end
      end else begin
        // end the frame, then retry this pair as a header
        emit_req     = 1'b1;
        res_count    = bits_seen_q;
        res_store    = bit_store_q;
        nxt_in_frame = !cls_i.last && cls_i.header;
        nxt_bits     = '0;
        nxt_store    = '0;
      end
    end else if (cls_i.header) begin
      emit_req     = cls_i.last;
      nxt_in_frame = !cls_i.last;
      nxt_bits     = '0;
      nxt_store    = '0;
    end

    len_ok = (res_count == sirc_pkg::LEN_SHORT) || (res_count == sirc_pkg::LEN_MID) ||
             (res_count == sirc_pkg::LEN_LONG);
  end

  assign advance_o = item_valid_i && (!emit_req || !out_valid_q || !out_stall_i);
  assign emit      = advance_o && emit_req;

  always_comb begin
    in_frame_d  = advance_o ? nxt_in_frame : in_frame_q;
    bits_seen_d = advance_o ? nxt_bits : bits_seen_q;
    bit_store_d = advance_o ? nxt_store : bit_store_q;

    out_valid_d     = out_valid_q && out_stall_i;
    frame_valid_d   = frame_valid_q;
    bit_count_d     = bit_count_q;
    command_value_d = command_value_q;
    if (emit) begin
      out_valid_d     = 1'b1;
      frame_valid_d   = len_ok;
      bit_count_d     = len_ok ? res_count : '0;
      command_value_d = len_ok ? res_store : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      bits_seen_q <= '0;
      bit_store_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      bits_seen_q <= bits_seen_d;
      bit_store_q <= bit_store_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_valid_q   <= frame_valid_d;
    bit_count_q     <= bit_count_d;
    command_value_q <= command_value_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_valid_o   = frame_valid_q;
  assign bit_count_o     = bit_count_q;
  assign command_value_o = command_value_q;

`ifndef SYNTHESIS
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (bits_seen_q == '0) && (bit_store_q == '0))
    else $error("idle state holds stale bits");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("result beat overwritten while stalled");

  a_valid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_valid_q |->
      (bit_count_q == sirc_pkg::LEN_SHORT) || (bit_count_q == sirc_pkg::LEN_MID) ||
      (bit_count_q == sirc_pkg::LEN_LONG))
    else $error("valid frame with illegal bit count");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !frame_valid_q |-> (bit_count_q == '0) && (command_value_q == '0))
    else $error("unknown frame carries data");
`endif

endmodule

@@ src/sony_ir_pulse_decoder.sv @@
// Top level of the infrared pulse decoder: input register, classifier, frame tracker.
// Path: input register, combinational classifier, then the frame tracker's result register.
// Throughput: one pulse pair per cycle; the input register and the result register
//   decouple the channels, so a stalled result only holds a pair that would emit.
// Reset: asynchronous, active low; clears the frame state and both valid flags and
//   loads the default timing registers.
`timescale 1ns / 1ps

module sony_ir_pulse_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sirc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sirc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           first_level_i,
  input  logic [sirc_pkg::TICKS_W-1:0]   first_ticks_i,
  input  logic                           second_level_i,
  input  logic [sirc_pkg::TICKS_W-1:0]   second_ticks_i,
  input  logic                           end_of_buffer_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           frame_valid_o,
  output logic [sirc_pkg::CNT_W-1:0]     bit_count_o,
  output logic [sirc_pkg::CMD_W-1:0]     command_value_o
);

  sirc_pkg::cfg_t        cfg;
  sirc_pkg::pair_class_t cls;

  logic                         item_valid_q, item_valid_d;
  logic                         first_level_q, first_level_d;
  logic [sirc_pkg::TICKS_W-1:0] first_ticks_q, first_ticks_d;
  logic                         second_level_q, second_level_d;
  logic [sirc_pkg::TICKS_W-1:0] second_ticks_q, second_ticks_d;
  logic                         last_q, last_d;
  logic                         advance;
  logic                         in_accept;

  assign in_stall_o = item_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d   = in_accept || (item_valid_q && !advance);
    first_level_d  = first_level_q;
    first_ticks_d  = first_ticks_q;
    second_level_d = second_level_q;
    second_ticks_d = second_ticks_q;
    last_d         = last_q;
    if (in_accept) begin
      first_level_d  = first_level_i;
      first_ticks_d  = first_ticks_i;
      second_level_d = second_level_i;
      second_ticks_d = second_ticks_i;
      last_d         = end_of_buffer_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_level_q  <= first_level_d;
    first_ticks_q  <= first_ticks_d;
    second_level_q <= second_level_d;
    second_ticks_q <= second_ticks_d;
    last_q         <= last_d;
  end

  sirc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sirc_classify u_classify (
    .cfg_i           (cfg),
    .first_level_i   (first_level_q),
    .first_ticks_i   (first_ticks_q),
    .second_level_i  (second_level_q),
    .second_ticks_i  (second_ticks_q),
    .end_of_buffer_i (last_q),
    .cls_o           (cls)
  );

  sirc_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid_q),
    .cls_i           (cls),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_valid_o   (frame_valid_o),
    .bit_count_o     (bit_count_o),
    .command_value_o (command_value_o)
  );

endmodule

@@ sim/sony_ir_pulse_decoder_test.sv @@
// Self-checking testbench for the infrared pulse decoder: random and directed pulse pairs.
`timescale 1ns / 1ps

module sony_ir_pulse_decoder_test;
  import sirc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic               first_level;
    logic [TICKS_W-1:0] first_ticks;
    logic               second_level;
    logic [TICKS_W-1:0] second_ticks;
    logic               end_of_buffer;
  } pair_t;

  typedef struct packed {
    logic              frame_valid;
    logic [CNT_W-1:0]  bit_count;
    logic [CMD_W-1:0]  command_value;
  } frame_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 first_level_i = 1'b0;
  logic [TICKS_W-1:0]   first_ticks_i = '0;
  logic                 second_level_i = 1'b0;
  logic [TICKS_W-1:0]   second_ticks_i = '0;
  logic                 end_of_buffer_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 frame_valid_o;
  logic [CNT_W-1:0]     bit_count_o;
  logic [CMD_W-1:0]     command_value_o;

  sony_ir_pulse_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_level_i  (first_level_i),
    .first_ticks_i  (first_ticks_i),
    .second_level_i (second_level_i),
    .second_ticks_i (second_ticks_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_valid_o  (frame_valid_o),
    .bit_count_o    (bit_count_o),
    .command_value_o(command_value_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  cfg_t             line_cfg;
  logic             in_frame = 1'b0;
  logic [CNT_W-1:0] bits_seen = '0;
  logic [CMD_W-1:0] bit_store = '0;

  pair_t       pairs_to_send[$];
  frame_t      frames_due[$];
  pair_t       send_beat;
  frame_t      predicted;
  frame_t      wanted;
  int          pushed = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned src_idle_pct = 25;
  int unsigned sink_idle_pct = 67;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  function automatic bit hits_target(logic [TICKS_W-1:0] ticks, logic [TGT_W-1:0] tgt);
    int us;
    int m;
    us = (int'(ticks) & ((1 << DURATION_BITS) - 1)) * 10 / TICKS_PER_10US;
    m = int'(line_cfg.slack_us);
    return (us < int'(tgt) + m) && (us + m > int'(tgt));
  endfunction

  function automatic bit well_formed(pair_t p);
    return p.first_level == line_cfg.active_level && p.second_level != line_cfg.active_level;
  endfunction

  function automatic bit is_header(pair_t p);
    return well_formed(p) && hits_target(p.first_ticks, line_cfg.header_mark_us)
        && hits_target(p.second_ticks, line_cfg.header_space_us);
  endfunction

  function automatic bit is_bit(pair_t p, logic [TGT_W-1:0] mark);
    return well_formed(p) && hits_target(p.first_ticks, mark)
        && (p.end_of_buffer || hits_target(p.second_ticks, line_cfg.bit_space_us));
  endfunction

  function automatic void open_frame();
    in_frame = 1'b1;
    bits_seen = '0;
    bit_store = '0;
  endfunction

  function automatic frame_t close_frame();
    frame_t f;
    f = '0;
    if (bits_seen == LEN_SHORT || bits_seen == LEN_MID || bits_seen == LEN_LONG) begin
      f.frame_valid = 1'b1;
      f.bit_count = bits_seen;
      f.command_value = bit_store;
    end
    in_frame = 1'b0;
    bits_seen = '0;
    bit_store = '0;
    return f;
  endfunction

  function automatic bit decode_pair(input pair_t p, output frame_t f);
    logic bit_val;
    logic got_bit;
    f = '0;
    if (!in_frame) begin
      if (!is_header(p)) return 1'b0;
      open_frame();
      if (!p.end_of_buffer) return 1'b0;
      f = close_frame();
      return 1'b1;
    end
    bit_val = is_bit(p, line_cfg.one_mark_us);
    got_bit = bit_val || is_bit(p, line_cfg.zero_mark_us);
    if (got_bit) begin
      if (bits_seen < CNT_STORE && bit_val) bit_store[bits_seen] = 1'b1;
      if (bits_seen < CNT_MAX) bits_seen++;
      if (!p.end_of_buffer) return 1'b0;
      f = close_frame();
      return 1'b1;
    end
    f = close_frame();
    if (!p.end_of_buffer && is_header(p)) open_frame();
    return 1'b1;
  endfunction

  function automatic void push_pair(bit fl, int ft, bit sl, int st, bit eob);
    pairs_to_send.push_back({fl, TICKS_W'(ft), sl, TICKS_W'(st), eob});
    pushed++;
  endfunction

  function automatic int jitter_ticks(int tgt);
    int j;
    int v;
    j = int'(line_cfg.slack_us) * 3 / 4;
    v = tgt - j + int'($urandom_range(2 * j));
    if (v < 0) v = 0;
    v = v * TICKS_PER_10US / 10;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic void push_mark(int mark_us, int space_us, bit eob);
    push_pair(line_cfg.active_level, jitter_ticks(mark_us),
              !line_cfg.active_level, jitter_ticks(space_us), eob);
  endfunction

  function automatic void push_noise(bit eob);
    push_pair(1'($urandom_range(1)), $urandom_range(32767), 1'($urandom_range(1)),
              $urandom_range(32767), eob);
  endfunction

  function automatic void queue_traffic(int n);
    int stop_at;
    int nbits;
    int ending;
    int mark;
    stop_at = pushed + n;
    while (pushed < stop_at) begin
      if ($urandom_range(99) < 22) begin
        push_noise(1'($urandom_range(1)));
        continue;
      end
      case ($urandom_range(4))
        0: nbits = 12;
        1: nbits = 15;
        2: nbits = 20;
        default: nbits = $urandom_range(34);
      endcase
      ending = $urandom_range(3);
      push_mark(line_cfg.header_mark_us, line_cfg.header_space_us, nbits == 0 && ending == 0);
      for (int i = 0; i < nbits; i++) begin
        mark = $urandom_range(1) ? line_cfg.one_mark_us : line_cfg.zero_mark_us;
        if (i == nbits - 1 && ending == 0)
          push_pair(line_cfg.active_level, jitter_ticks(mark), !line_cfg.active_level,
                    $urandom_range(32767), 1'b1);
        else
          push_mark(mark, line_cfg.bit_space_us, 1'b0);
      end
      if (ending == 1) push_noise(1'b0);
      else if (ending == 3) push_noise(1'b1);
    end
  endfunction

  task automatic drive_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
  endtask

  task automatic apply_setting(cfg_t c);
    drive_reg(REG_ACTIVE_LEVEL, CFG_W'(c.active_level));
    drive_reg(REG_MARGIN, CFG_W'(c.slack_us));
    drive_reg(REG_HEADER_MARK, c.header_mark_us);
    drive_reg(REG_HEADER_SPACE, c.header_space_us);
    drive_reg(REG_ONE_MARK, c.one_mark_us);
    drive_reg(REG_ZERO_MARK, c.zero_mark_us);
    drive_reg(REG_BIT_SPACE, c.bit_space_us);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    line_cfg = c;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pairs_to_send.size() != 0 || in_valid_i || frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pairs_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        send_beat = pairs_to_send.pop_front();
        in_valid_i <= 1'b1;
        first_level_i <= send_beat.first_level;
        first_ticks_i <= send_beat.first_ticks;
        second_level_i <= send_beat.second_level;
        second_ticks_i <= send_beat.second_ticks;
        end_of_buffer_i <= send_beat.end_of_buffer;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (decode_pair({first_level_i, first_ticks_i, second_level_i, second_ticks_i,
                         end_of_buffer_i}, predicted))
          frames_due.push_back(predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          $display("%0t: expected no beat, got valid %0d count %0d command %h", $time,
                   frame_valid_o, bit_count_o, command_value_o);
          mismatches++;
        end else begin
          wanted = frames_due.pop_front();
          if (frame_valid_o !== wanted.frame_valid) begin
            $display("%0t: frame_valid expected %0d got %0d", $time,
                     wanted.frame_valid, frame_valid_o);
            mismatches++;
          end
          if (bit_count_o !== wanted.bit_count) begin
            $display("%0t: bit_count expected %0d got %0d", $time,
                     wanted.bit_count, bit_count_o);
            mismatches++;
          end
          if (command_value_o !== wanted.command_value) begin
            $display("%0t: command_value expected %h got %h", $time,
                     wanted.command_value, command_value_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    line_cfg = '{active_level: RST_ACTIVE_LEVEL, slack_us: RST_MARGIN,
                 header_mark_us: RST_HEADER_MARK, header_space_us: RST_HEADER_SPACE,
                 one_mark_us: RST_ONE_MARK, zero_mark_us: RST_ZERO_MARK,
                 bit_space_us: RST_BIT_SPACE};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_pair(1'b1, 32767, 1'b0, 32767, 1'b0);
    push_pair(1'b0, 0, 1'b0, 0, 1'b1);
    push_pair(1'b0, 1920, 1'b1, 480, 1'b1);
    push_pair(1'b0, 1999, 1'b1, 480, 1'b0);
    for (int i = 0; i < 12; i++)
      push_pair(1'b0, (12'hA5C >> i) & 1 ? 960 : 480, 1'b1, i == 11 ? 32767 : 480, i == 11);
    push_pair(1'b0, 2000, 1'b1, 480, 1'b0);
    push_pair(1'b0, 1840, 1'b1, 480, 1'b0);
    push_pair(1'b0, 1841, 1'b1, 480, 1'b0);
    push_pair(1'b0, 960, 1'b1, 480, 1'b0);
    push_pair(1'b0, 480, 1'b1, 480, 1'b0);
    push_pair(1'b0, 1920, 1'b1, 480, 1'b0);
    push_pair(1'b1, 0, 1'b0, 0, 1'b1);
    wait_drained();

    queue_traffic(600);
    wait_drained();

    src_idle_pct = 67;
    sink_idle_pct = 25;
    apply_setting('{active_level: 1'b1, slack_us: 12'd250, header_mark_us: 15'd3000,
                    header_space_us: 15'd700, one_mark_us: 15'd1500,
                    zero_mark_us: 15'd800, bit_space_us: 15'd500});
    queue_traffic(600);
    wait_drained();

    apply_setting('{active_level: 1'b0, slack_us: 12'd0, header_mark_us: 15'd2400,
                    header_space_us: 15'd600, one_mark_us: 15'd1200,
                    zero_mark_us: 15'd600, bit_space_us: 15'd600});
    queue_traffic(40);
    wait_drained();

    apply_setting('{active_level: 1'b1, slack_us: 12'd4095, header_mark_us: 15'd32767,
                    header_space_us: 15'd0, one_mark_us: 15'd0,
                    zero_mark_us: 15'd32767, bit_space_us: 15'd32767});
    queue_traffic(80);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    apply_setting('{active_level: 1'b0, slack_us: 12'd100, header_mark_us: 15'd2400,
                    header_space_us: 15'd600, one_mark_us: 15'd1200,
                    zero_mark_us: 15'd600, bit_space_us: 15'd600});
    hold_armed = 1'b1;
    queue_traffic(600);
    wait_drained();

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
